FILE: sv/read_group_species_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// Read-group species classifier: assertion macros
// Concurrent check wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef READ_GROUP_SPECIES_CLASSIFIER_CORE_MACROS_SVH
`define READ_GROUP_SPECIES_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define RGSC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rgsc check failed");
// Next-cycle implication check.
`define RGSC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rgsc check failed");
`else
`define RGSC_ASSERT_IMP(name, clk, rstn, ante, cons)
`define RGSC_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/rgsc_pkg.sv
// ----------------------------------------------------------------------------
// Read-group species classifier: shared package
// Verdict codes, slot geometry, start values and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgsc_pkg;

  localparam int NUM_ROWS    = 3;
  localparam int NUM_SLOTS   = 4;
  localparam int TAG_FIELD_W = 16;

  // Start values of a slot in score mode and in tag mode.
  localparam int SCORE_START = 8192;
  localparam int TAG_START   = -8192;

  // Tag rows in tag mode.
  localparam int ROW_AS = 0;
  localparam int ROW_NM = 1;
  localparam int ROW_XS = 2;

  typedef enum logic [1:0] {
    VERDICT_AMBIG  = 2'd0,
    VERDICT_A      = 2'd1,
    VERDICT_B      = 2'd2,
    VERDICT_ABSENT = 2'd3
  } verdict_t;

  // Control of one slot update.
  typedef struct packed {
    logic apply;
    logic mode;
    logic mapped;
    logic species;
    logic first_mate;
  } rgsc_upd_ctl_t;

  // Group summary that goes along with a slot snapshot.
  typedef struct packed {
    logic       mode;
    logic [1:0] seen;
  } rgsc_grp_ctl_t;

endpackage

`default_nettype wire

FILE: sv/rgsc_slot_bank.sv
// ----------------------------------------------------------------------------
// Read-group species classifier: slot bank
// Holds the twelve slot scores and folds one record into them per cycle while ctl.apply is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgsc_slot_bank
  import rgsc_pkg::*;
#(
  parameter int TAG_W  = 16,
  parameter int SLOT_W = 19
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire rgsc_upd_ctl_t                                ctl,
  input  wire logic [TAG_W-1:0]                             nm_tag,
  input  wire logic [TAG_W-1:0]                             xo_tag,
  input  wire logic [TAG_W-1:0]                             nh_tag,
  input  wire logic [TAG_W-1:0]                             as_tag,
  input  wire logic [TAG_W-1:0]                             xs_tag,
  input  wire logic                                         clear,
  input  wire logic                                         clear_mode,
  output logic      [NUM_ROWS-1:0][NUM_SLOTS-1:0][SLOT_W-1:0] slot_upd
);

  localparam logic [SLOT_W-1:0] START_SCORE = SLOT_W'(SCORE_START);
  localparam logic [SLOT_W-1:0] START_TAG   = SLOT_W'(TAG_START);

  logic [NUM_ROWS-1:0][NUM_SLOTS-1:0][SLOT_W-1:0] slot_r;
  logic [NUM_ROWS-1:0][SLOT_W-1:0]                cand;
  logic [TAG_W+1:0]                               sum;
  logic [1:0]                                     slot_idx;

  // The second mate sits in the odd slot of its species.
  assign slot_idx = {ctl.species, ~ctl.first_mate};
  assign sum      = {2'b00, nm_tag} + {2'b00, xo_tag} + {2'b00, nh_tag};

  always_comb begin
    cand[ROW_AS] = ctl.mode ? SLOT_W'(as_tag) : SLOT_W'(sum);
    cand[ROW_NM] = '0 - SLOT_W'(nm_tag);
    cand[ROW_XS] = SLOT_W'(xs_tag);
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_upd[r][s] = slot_r[r][s];
        if (ctl.mapped && (slot_idx == 2'(s))) begin
          if (ctl.mode) begin
            if ($signed(cand[r]) > $signed(slot_r[r][s])) begin
              slot_upd[r][s] = cand[r];
            end
          end else if (r == ROW_AS) begin
            if ($signed(cand[r]) < $signed(slot_r[r][s])) begin
              slot_upd[r][s] = cand[r];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= {(NUM_ROWS * NUM_SLOTS){START_SCORE}};
    end else if (clear) begin
      slot_r <= {(NUM_ROWS * NUM_SLOTS){clear_mode ? START_TAG : START_SCORE}};
    end else if (ctl.apply) begin
      slot_r <= slot_upd;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rgsc_decide.sv
// ----------------------------------------------------------------------------
// Read-group species classifier: verdict logic
// Compares the per-species min and max of each row and picks a verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgsc_decide
  import rgsc_pkg::*;
#(
  parameter int SLOT_W = 19
) (
  input  wire logic [NUM_ROWS-1:0][NUM_SLOTS-1:0][SLOT_W-1:0] slots,
  input  wire rgsc_grp_ctl_t                                  grp,
  output verdict_t                                            verdict
);

  logic signed [SLOT_W-1:0] amin [NUM_ROWS];
  logic signed [SLOT_W-1:0] amax [NUM_ROWS];
  logic signed [SLOT_W-1:0] bmin [NUM_ROWS];
  logic signed [SLOT_W-1:0] bmax [NUM_ROWS];
  logic [NUM_ROWS-1:0]      row_a;
  logic [NUM_ROWS-1:0]      row_b;
  verdict_t                 score_v;
  verdict_t                 tag_v;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      if ($signed(slots[r][0]) < $signed(slots[r][1])) begin
        amin[r] = $signed(slots[r][0]);
        amax[r] = $signed(slots[r][1]);
      end else begin
        amin[r] = $signed(slots[r][1]);
        amax[r] = $signed(slots[r][0]);
      end
      if ($signed(slots[r][2]) < $signed(slots[r][3])) begin
        bmin[r] = $signed(slots[r][2]);
        bmax[r] = $signed(slots[r][3]);
      end else begin
        bmin[r] = $signed(slots[r][3]);
        bmax[r] = $signed(slots[r][2]);
      end
      row_a[r] = (amax[r] > bmax[r]) || ((amax[r] == bmax[r]) && (amin[r] > bmin[r]));
      row_b[r] = (amax[r] < bmax[r]) || ((amax[r] == bmax[r]) && (amin[r] < bmin[r]));
    end
  end

  // Score mode: the lower summed score wins, minimum first.
  always_comb begin
    if ((amin[ROW_AS] == bmin[ROW_AS]) && (amax[ROW_AS] == bmax[ROW_AS])) begin
      score_v = VERDICT_AMBIG;
    end else if ((amin[ROW_AS] < bmin[ROW_AS]) ||
                 ((amin[ROW_AS] == bmin[ROW_AS]) && (amax[ROW_AS] < bmax[ROW_AS]))) begin
      score_v = VERDICT_A;
    end else begin
      score_v = VERDICT_B;
    end
  end

  // Tag mode: the first row that is not a full tie decides.
  always_comb begin
    tag_v = VERDICT_AMBIG;
    for (int r = NUM_ROWS - 1; r >= 0; r--) begin
      if (row_a[r]) begin
        tag_v = VERDICT_A;
      end else if (row_b[r]) begin
        tag_v = VERDICT_B;
      end
    end
  end

  always_comb begin
    if (grp.seen != 2'b11) begin
      verdict = VERDICT_ABSENT;
    end else if (grp.mode) begin
      verdict = tag_v;
    end else begin
      verdict = score_v;
    end
  end

endmodule

`default_nettype wire

FILE: sv/read_group_species_classifier_core.sv
// ----------------------------------------------------------------------------
// Read-group species classifier core
// Scores the alignment records of a read group against two species and
// gives one verdict per group.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Carries
//  --------+-----------+------------------------+------------------------------
//  in_     | input     | in_valid / in_stall    | one alignment record
//  out_    | output    | out_valid / out_stall  | one verdict per read group
//  cfg_    | input     | cfg_valid / cfg_ready  | align_mode register write
//
//  The core takes one record request in every cycle unless in_stall is high. A
//  verdict appears once its group-end record has passed the input register,
//  the snapshot register and the result register. Reset is synchronous and
//  active low; it selects score mode and starts every slot at the score start
//  value. A stalled result backs up through the snapshot stage to the input
//  register within the same cycle.
//
`timescale 1ns / 1ps
`default_nettype none
`include "read_group_species_classifier_core_macros.svh"

module read_group_species_classifier_core
  import rgsc_pkg::*;
#(
  parameter int TAG_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Record channel.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   in_species,
  input  wire logic                   in_mapped,
  input  wire logic                   in_first_mate,
  input  wire logic [TAG_FIELD_W-1:0] in_nm_tag,
  input  wire logic [TAG_FIELD_W-1:0] in_xo_tag,
  input  wire logic [TAG_FIELD_W-1:0] in_nh_tag,
  input  wire logic [TAG_FIELD_W-1:0] in_as_tag,
  input  wire logic [TAG_FIELD_W-1:0] in_xs_tag,
  input  wire logic                   in_group_end,
  // Verdict channel.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_verdict,
  // Configuration channel.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_align_mode
);

  // Only the low tag bits that fit the record fields take part.
  localparam int USE_W   = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;
  // Slots hold the summed score, a raw tag, or a start value of magnitude 8192.
  localparam int SLOT_W  = ((USE_W + 2 > 14) ? (USE_W + 2) : 14) + 1;
  localparam logic [SLOT_W-1:0] START_SCORE_W = SLOT_W'(SCORE_START);

  // Input register.
  logic             in_v_r;
  logic             in_species_r;
  logic             in_mapped_r;
  logic             in_first_r;
  logic             in_gend_r;
  logic [USE_W-1:0] in_nm_r;
  logic [USE_W-1:0] in_xo_r;
  logic [USE_W-1:0] in_nh_r;
  logic [USE_W-1:0] in_as_r;
  logic [USE_W-1:0] in_xs_r;

  // Group state.
  logic             mode_r;
  logic [1:0]       seen_r;
  logic [1:0]       seen_upd;

  // Snapshot of a finished group.
  logic                                           snap_v_r;
  logic [NUM_ROWS-1:0][NUM_SLOTS-1:0][SLOT_W-1:0] snap_slots_r;
  rgsc_grp_ctl_t                                  snap_grp_r;

  // Result register.
  logic             out_valid_r;
  verdict_t         verdict_r;

  logic                                           in_accept;
  logic                                           in_drain;
  logic                                           apply;
  logic                                           snap_load;
  logic                                           snap_ready;
  logic                                           out_ready;
  logic                                           out_load;
  logic                                           cfg_we;
  logic                                           clear;
  logic                                           clear_mode;
  rgsc_upd_ctl_t                                  upd_ctl;
  logic [NUM_ROWS-1:0][NUM_SLOTS-1:0][SLOT_W-1:0] slot_upd;
  verdict_t                                       verdict_nxt;

  // Handshake chain, from the result side back to the input side. A record
  // that does not end its group leaves the input register at once; a
  // group-end record needs room in the snapshot stage.
  assign out_ready  = !out_valid_r || !out_stall;
  assign out_load   = snap_v_r && out_ready;
  assign snap_ready = !snap_v_r || out_ready;
  assign in_drain   = !in_gend_r || snap_ready;
  assign in_stall   = in_v_r && !in_drain;
  assign in_accept  = in_valid && !in_stall;
  assign apply      = in_v_r && in_drain;
  assign snap_load  = apply && in_gend_r;

  // The mode register is written only while nothing is in flight.
  assign cfg_ready  = !in_v_r && !snap_v_r && !out_valid_r;
  assign cfg_we     = cfg_valid && cfg_ready;

  // A mode write or a finished group restarts every slot.
  assign clear      = cfg_we || snap_load;
  assign clear_mode = cfg_we ? cfg_align_mode : mode_r;

  // Unmapped records still count as presence of their species.
  assign seen_upd   = seen_r | (in_species_r ? 2'b10 : 2'b01);

  always_comb begin
    upd_ctl.apply      = apply;
    upd_ctl.mode       = mode_r;
    upd_ctl.mapped     = in_mapped_r;
    upd_ctl.species    = in_species_r;
    upd_ctl.first_mate = in_first_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_accept) begin
      in_v_r <= 1'b1;
    end else if (in_drain) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_species_r <= in_species;
      in_mapped_r  <= in_mapped;
      in_first_r   <= in_first_mate;
      in_gend_r    <= in_group_end;
      in_nm_r      <= in_nm_tag[USE_W-1:0];
      in_xo_r      <= in_xo_tag[USE_W-1:0];
      in_nh_r      <= in_nh_tag[USE_W-1:0];
      in_as_r      <= in_as_tag[USE_W-1:0];
      in_xs_r      <= in_xs_tag[USE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      seen_r <= 2'b00;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_align_mode;
      end
      if (clear) begin
        seen_r <= 2'b00;
      end else if (apply) begin
        seen_r <= seen_upd;
      end
    end
  end

  rgsc_slot_bank #(
    .TAG_W  (USE_W),
    .SLOT_W (SLOT_W)
  ) u_bank (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (upd_ctl),
    .nm_tag     (in_nm_r),
    .xo_tag     (in_xo_r),
    .nh_tag     (in_nh_r),
    .as_tag     (in_as_r),
    .xs_tag     (in_xs_r),
    .clear      (clear),
    .clear_mode (clear_mode),
    .slot_upd   (slot_upd)
  );

  // The snapshot takes the slots with the group-end record already folded in,
  // so the live bank can restart for the next group in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (snap_load) begin
      snap_v_r <= 1'b1;
    end else if (out_ready) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_slots_r    <= slot_upd;
      snap_grp_r.mode <= mode_r;
      snap_grp_r.seen <= seen_upd;
    end
  end

  rgsc_decide #(
    .SLOT_W (SLOT_W)
  ) u_decide (
    .slots   (snap_slots_r),
    .grp     (snap_grp_r),
    .verdict (verdict_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict_r <= verdict_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;

  // A verdict that leaves is either replaced from the snapshot or gone.
  `RGSC_ASSERT_NXT(a_out_refill, clk, rst_n, out_valid_r && !out_stall,
                   !out_valid_r || $past(snap_v_r))

  // Once a group-end record is folded in, the next group starts unseen.
  `RGSC_ASSERT_NXT(a_group_restart, clk, rst_n, snap_load, seen_r == 2'b00)

  // In score mode a finished group never holds a slot above the start value.
  `RGSC_ASSERT_IMP(a_score_bound, clk, rst_n, snap_v_r && !snap_grp_r.mode,
                   ($signed(snap_slots_r[ROW_AS][0]) <= $signed(START_SCORE_W)) &&
                   ($signed(snap_slots_r[ROW_AS][1]) <= $signed(START_SCORE_W)) &&
                   ($signed(snap_slots_r[ROW_AS][2]) <= $signed(START_SCORE_W)) &&
                   ($signed(snap_slots_r[ROW_AS][3]) <= $signed(START_SCORE_W)))

endmodule

`default_nettype wire
